// File: hw/rtl/rc_link_frame_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// rc link frame decoder assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_DECODER_TOP_MACROS_SVH
`define RC_LINK_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define RCFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc link frame decoder check failed");

// next-cycle implication
`define RCFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc link frame decoder check failed");

`endif

// File: hw/rtl/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// shared types and constants of the rc link frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rcfd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_DERIV,
		ST_STAT,
		ST_HB,
		ST_ZERO
	} state_t;

	localparam logic [1:0] KIND_RAW   = 2'd0;
	localparam logic [1:0] KIND_DERIV = 2'd1;
	localparam logic [1:0] KIND_STAT  = 2'd2;
	localparam logic [1:0] KIND_HB    = 2'd3;

	localparam logic [1:0] CFG_ADDR  = 2'd0;
	localparam logic [1:0] CFG_RC    = 2'd1;
	localparam logic [1:0] CFG_STATS = 2'd2;
	localparam logic [1:0] CFG_HB    = 2'd3;

	localparam int NUM_CH     = 16;
	localparam int USED_BYTES = 25;
	localparam int PAY_BYTES  = 22;
	localparam int PAY_FIRST  = 3;

	localparam logic [3:0] LAST_RAW   = 4'd15;
	localparam logic [3:0] LAST_DERIV = 4'd11;
	localparam logic [3:0] LAST_STAT  = 4'd9;

	typedef logic [10:0] chan_t;
	typedef logic signed [15:0] value_t;

	localparam chan_t CH_LO    = 11'd174;
	localparam chan_t CH_MID   = 11'd992;
	localparam chan_t CH_HI_A  = 11'd1808;
	localparam chan_t CH_HI_B  = 11'd1811;
	localparam chan_t SW_LOW   = 11'd191;
	localparam chan_t SW_HIGH  = 11'd229;
	localparam chan_t SW_NONE  = 11'd0;

	localparam value_t Q8_FULL = 16'sd25600;
	localparam logic signed [18:0] BASE_LO_SYM  = -19'sd81800;
	localparam logic signed [18:0] BASE_HI_ASYM = 19'sd40950;
	localparam logic [6:0] SPAN_FULL = 7'd100;
	localparam logic [6:0] SPAN_HALF = 7'd50;

	// reciprocals for exact floor division of (|q| << 8) by the half-range widths
	localparam int RECIP_SHIFT = 27;
	localparam logic [25:0] RECIP_LO   = 26'(((64'd1 << 35) + 64'd817) / 64'd818);
	localparam logic [25:0] RECIP_HI_A = 26'(((64'd1 << 35) + 64'd815) / 64'd816);
	localparam logic [25:0] RECIP_HI_B = 26'(((64'd1 << 35) + 64'd818) / 64'd819);

	localparam logic [2:0] STICKS = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/rc_link_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// rc_link_frame_decoder_top
// collects link bytes into a frame and decodes rc, statistics and heartbeat
//
// channel   signals                            direction
// in        in_valid/in_ready, rx_byte ...     byte words in
// out       out_valid/out_ready, result_kind   result words out
// cfg       cfg_valid/cfg_ready, cfg_index     register writes
//
// one byte word per cycle; a frame end starts a run of up to 28 result words,
// one per cycle through the output register while out_ready does not stall it
// a frame end word waits in the input register while a run is draining
// stick maps pass the s1 and s2 multiplier registers, hidden behind the raw words
// reset clears the frame buffer, counters and config registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module rc_link_frame_decoder_top import rcfd_pkg::*; #(
	parameter int FRAME_BYTES = 36
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               frame_end,
	input  wire logic               link_online,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              result_kind,
	output logic [3:0]              slot,
	output logic signed [15:0]      result_value,
	output logic [31:0]             frames_received,
	output logic                    last_of_run,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);

	localparam int WP_W = $clog2(FRAME_BYTES + 1);

	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              fe_s1;
	logic              online_s1;
	logic              busy;
	logic              take_s1;
	logic              snap_go;

	logic [7:0]        buf_q [USED_BYTES];
	logic [WP_W-1:0]   wp_q;
	logic [7:0]        frame_b [USED_BYTES];

	logic [7:0]        pay_q [PAY_BYTES];
	logic [8*PAY_BYTES-1:0] pay_bits;
	chan_t             ch [NUM_CH];
	logic              online_q;
	logic [31:0]       frames_q;
	logic              match;

	logic [7:0]        addr_q, rc_type_q, stats_type_q, hb_type_q;

	state_t            state_q, state_d;
	logic [3:0]        cnt_q, cnt_d;
	logic              advance;
	logic [1:0]        e_kind;
	logic [3:0]        e_slot;
	value_t            e_val;
	value_t            deriv_val;
	logic              e_last;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [3:0]        slot_q;
	value_t            value_q;
	logic [31:0]       count_q;
	logic              last_q;

	// stick unit
	logic [2:0]        sc_q;
	chan_t             sv;
	logic              s_hib, s_asym, s_lower, s_lowc, s_highc;
	chan_t             s_off;
	logic [6:0]        s_span;
	logic [17:0]       s_ospan;
	logic signed [18:0] s_base, s_q, s_abs;
	logic [25:0]       s_recip;
	value_t            s_cval;
	logic              stk_v_s1, stk_v_s2;
	logic [16:0]       stk_abs_s1;
	logic [25:0]       stk_recip_s1;
	logic              stk_neg_s1, stk_neg_s2;
	logic              stk_clamp_s1, stk_clamp_s2;
	value_t            stk_cval_s1, stk_cval_s2;
	logic [1:0]        stk_idx_s1, stk_idx_s2;
	logic [42:0]       stk_prod_s2;
	logic [15:0]       stk_quo;
	value_t            stk_val;
	value_t            stick_q [4];

	function automatic value_t tri_sw(input chan_t c);
		value_t r;
		if (c == SW_LOW) r = 16'sd0;
		else if (c == SW_HIGH) r = 16'sd1;
		else if (c == SW_NONE) r = 16'sd2;
		else r = value_t'({5'b0, c});
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign in_ready  = !v_s1 || !(fe_s1 && busy);
	assign take_s1   = v_s1 && !(fe_s1 && busy);
	assign snap_go   = take_s1 && fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1   <= rx_byte;
			fe_s1     <= frame_end;
			online_s1 <= link_online;
		end
	end

	always_comb begin
		for (int i = 0; i < USED_BYTES; i++) begin
			frame_b[i] = (wp_q == WP_W'(i)) ? byte_s1 : buf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int i = 0; i < USED_BYTES; i++) buf_q[i] <= 8'd0;
		end else if (take_s1) begin
			if (fe_s1) begin
				wp_q <= '0;
				for (int i = 0; i < USED_BYTES; i++) buf_q[i] <= 8'd0;
			end else begin
				if (wp_q < WP_W'(FRAME_BYTES)) wp_q <= wp_q + 1'b1;
				for (int i = 0; i < USED_BYTES; i++) begin
					if (wp_q == WP_W'(i)) buf_q[i] <= byte_s1;
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= 8'd200;
			rc_type_q    <= 8'd22;
			stats_type_q <= 8'd20;
			hb_type_q    <= 8'd11;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ADDR:  addr_q       <= cfg_data;
				CFG_RC:    rc_type_q    <= cfg_data;
				CFG_STATS: stats_type_q <= cfg_data;
				CFG_HB:    hb_type_q    <= cfg_data;
				default:   addr_q       <= addr_q;
			endcase
		end
	end

	assign match = (frame_b[0] == addr_q);

	// frame snapshot
	always_ff @(posedge clk) begin
		if (snap_go) begin
			online_q <= online_s1;
			for (int i = 0; i < PAY_BYTES; i++) pay_q[i] <= frame_b[PAY_FIRST + i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 32'd0;
		end else if (snap_go && match) begin
			frames_q <= frames_q + 32'd1;
		end
	end

	always_comb begin
		for (int i = 0; i < PAY_BYTES; i++) pay_bits[8*i +: 8] = pay_q[i];
		for (int k = 0; k < NUM_CH; k++) ch[k] = pay_bits[11*k +: 11];
	end

	// stick maps: select and offset, reciprocal multiply, scale, sign and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= STICKS;
		end else if (snap_go) begin
			sc_q <= 3'd0;
		end else if (sc_q != STICKS) begin
			sc_q <= sc_q + 3'd1;
		end
	end

	always_comb begin
		unique case (sc_q[1:0])
			2'd0: begin sv = ch[3]; s_hib = 1'b0; s_asym = 1'b0; end
			2'd1: begin sv = ch[2]; s_hib = 1'b1; s_asym = 1'b1; end
			2'd2: begin sv = ch[0]; s_hib = 1'b1; s_asym = 1'b0; end
			default: begin sv = ch[1]; s_hib = 1'b0; s_asym = 1'b0; end
		endcase
		s_lower = sv < CH_MID;
		s_lowc  = sv < CH_LO;
		s_highc = sv > (s_hib ? CH_HI_B : CH_HI_A);
		s_off   = s_lower ? (sv - CH_LO) : (sv - CH_MID);
		s_span  = s_asym ? SPAN_HALF : SPAN_FULL;
		s_ospan = 18'(s_off) * 18'(s_span);
		if (s_lower) s_base = s_asym ? 19'sd0 : BASE_LO_SYM;
		else s_base = s_asym ? BASE_HI_ASYM : 19'sd0;
		s_q     = s_base + $signed({1'b0, s_ospan});
		s_abs   = s_q[18] ? -s_q : s_q;
		if (s_lower) s_recip = RECIP_LO;
		else s_recip = s_hib ? RECIP_HI_B : RECIP_HI_A;
		if (s_lowc) s_cval = s_asym ? 16'sd0 : -Q8_FULL;
		else s_cval = Q8_FULL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_v_s1 <= 1'b0;
			stk_v_s2 <= 1'b0;
		end else begin
			stk_v_s1 <= (sc_q != STICKS);
			stk_v_s2 <= stk_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		stk_abs_s1   <= s_abs[16:0];
		stk_recip_s1 <= s_recip;
		stk_neg_s1   <= s_q[18];
		stk_clamp_s1 <= s_lowc || s_highc;
		stk_cval_s1  <= s_cval;
		stk_idx_s1   <= sc_q[1:0];
		stk_prod_s2  <= 43'(stk_abs_s1) * 43'(stk_recip_s1);
		stk_neg_s2   <= stk_neg_s1;
		stk_clamp_s2 <= stk_clamp_s1;
		stk_cval_s2  <= stk_cval_s1;
		stk_idx_s2   <= stk_idx_s1;
	end

	assign stk_quo = stk_prod_s2[RECIP_SHIFT +: 16];
	assign stk_val = stk_clamp_s2 ? stk_cval_s2 :
		(stk_neg_s2 ? -$signed(stk_quo) : $signed(stk_quo));

	always_ff @(posedge clk) begin
		if (stk_v_s2) stick_q[stk_idx_s2] <= stk_val;
	end

	// derived controls
	always_comb begin
		unique case (cnt_q)
			4'd0, 4'd1, 4'd2, 4'd3: deriv_val = stick_q[cnt_q[1:0]];
			4'd4:  deriv_val = tri_sw(ch[6]);
			4'd5:  deriv_val = tri_sw(ch[7]);
			4'd6:  deriv_val = value_t'({15'd0, ch[4] != SW_LOW});
			4'd7:  deriv_val = value_t'({15'd0, ch[5] != SW_LOW});
			4'd8:  deriv_val = value_t'({15'd0, ch[8] != SW_LOW});
			4'd9:  deriv_val = value_t'({15'd0, ch[9] != SW_LOW});
			4'd10: deriv_val = value_t'({5'd0, ch[11]}) - value_t'({5'd0, SW_LOW});
			4'd11: deriv_val = value_t'({5'd0, ch[10]}) - value_t'({5'd0, SW_LOW});
			default: deriv_val = 16'sd0;
		endcase
	end

	// run sequencer
	assign advance = busy && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		e_kind  = KIND_DERIV;
		e_slot  = cnt_q;
		e_val   = 16'sd0;
		e_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (snap_go) begin
					cnt_d = 4'd0;
					priority if (match && frame_b[2] == rc_type_q) state_d = ST_RAW;
					else if (match && frame_b[2] == stats_type_q) state_d = ST_STAT;
					else if (match && frame_b[2] == hb_type_q) state_d = ST_HB;
					else if (!online_s1) state_d = ST_ZERO;
					else state_d = ST_IDLE;
				end
			end
			ST_RAW: begin
				e_kind = KIND_RAW;
				e_val  = value_t'({5'd0, ch[cnt_q]});
				if (advance) begin
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == LAST_RAW) state_d = ST_DERIV;
				end
			end
			ST_DERIV: begin
				e_val  = online_q ? deriv_val : 16'sd0;
				e_last = (cnt_q == LAST_DERIV);
				if (advance) begin
					cnt_d = e_last ? 4'd0 : cnt_q + 4'd1;
					if (e_last) state_d = ST_IDLE;
				end
			end
			ST_STAT: begin
				e_kind = KIND_STAT;
				if (cnt_q == 4'd3 || cnt_q == LAST_STAT)
					e_val = value_t'(signed'(pay_q[{1'b0, cnt_q}]));
				else
					e_val = value_t'({8'd0, pay_q[{1'b0, cnt_q}]});
				e_last = (cnt_q == LAST_STAT) && online_q;
				if (advance) begin
					if (cnt_q == LAST_STAT) begin
						cnt_d   = 4'd0;
						state_d = online_q ? ST_IDLE : ST_ZERO;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			ST_HB: begin
				e_kind = KIND_HB;
				e_slot = 4'd0;
				e_val  = value_t'({8'd0, pay_q[0]});
				e_last = online_q;
				if (advance) begin
					cnt_d   = 4'd0;
					state_d = online_q ? ST_IDLE : ST_ZERO;
				end
			end
			ST_ZERO: begin
				e_last = (cnt_q == LAST_DERIV);
				if (advance) begin
					cnt_d = e_last ? 4'd0 : cnt_q + 4'd1;
					if (e_last) state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q  <= e_kind;
			slot_q  <= e_slot;
			value_q <= e_val;
			count_q <= frames_q;
			last_q  <= e_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign slot            = slot_q;
	assign result_value    = value_q;
	assign frames_received = count_q;
	assign last_of_run     = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/rcfd_checker.sv
// ----------------------------------------------------------------------------
// rcfd_checker
// port-level checks of the rc link frame decoder result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_link_frame_decoder_top_macros.svh"

module rcfd_checker import rcfd_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [1:0]         result_kind,
	input wire logic [3:0]         slot,
	input wire logic signed [15:0] result_value,
	input wire logic               last_of_run
);

	`RCFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(last_of_run))
	`RCFD_ASSERT_NOW(a_raw_not_last, out_valid && result_kind == KIND_RAW, !last_of_run)
	`RCFD_ASSERT_NOW(a_deriv_slot, out_valid && result_kind == KIND_DERIV, slot <= 4'd11)
	`RCFD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid)

endmodule

bind rc_link_frame_decoder_top rcfd_checker u_rcfd_checker (.*);

`default_nettype wire
